### rtl/mps_pkg.sv
// ----------------------------------------------------------------------------
// mps_pkg
// shared constants, codes and register map of the meter poll supervisor
// ----------------------------------------------------------------------------
package mps_pkg;

    // field widths
    localparam int unsigned EnergyW = 32;
    localparam int unsigned PowerW  = 16;
    localparam int unsigned CountW  = 5;
    localparam int unsigned LimitW  = 4;

    // configuration port
    localparam int unsigned AddrW = 3;
    localparam int unsigned DataW = 32;

    // register indexes (byte address bit 2)
    localparam logic RegRetryLimit   = 1'b0;
    localparam logic RegRestartLimit = 1'b1;

    // register reset values
    localparam logic [LimitW-1:0] RetryLimitRst   = 4'd3;
    localparam logic [LimitW-1:0] RestartLimitRst = 4'd3;

    // milliseconds per hour and the product width it gives with a 32-bit energy
    localparam int unsigned         MsPerHourW = 22;
    localparam logic [MsPerHourW-1:0] MsPerHour = 22'd3600000;
    localparam int unsigned         ProdW      = EnergyW + MsPerHourW;

    // counters saturate here
    localparam logic [CountW-1:0] CountMax = 5'd31;

    // action codes
    typedef enum logic [1:0] {
        ACT_ADVANCE = 2'd0,
        ACT_STAY    = 2'd1,
        ACT_ERROR   = 2'd2
    } t_action;

    // wait before next poll
    typedef enum logic [1:0] {
        WAIT_100MS = 2'd0,
        WAIT_5S    = 2'd1,
        WAIT_30S   = 2'd2
    } t_wait;

    // line power actions
    typedef enum logic [1:0] {
        LINE_NONE    = 2'd0,
        LINE_OFF_1   = 2'd1,
        LINE_OFF_2   = 2'd2,
        LINE_ON_BOTH = 2'd3
    } t_line_action;

endpackage

### rtl/mps_if.sv
// ----------------------------------------------------------------------------
// mps_if
// valid/ready channels of the meter poll supervisor: poll beats in,
// result beats out
// ----------------------------------------------------------------------------
interface mps_in_if;
    logic        valid;
    logic        ready;
    logic        line1_ok;
    logic        line2_ok;
    logic [31:0] energy_line1_wh;
    logic [31:0] energy_line2_wh;
    logic [31:0] energy_home_wh;
    logic [31:0] now_ms;

    modport source (
        output valid, line1_ok, line2_ok, energy_line1_wh, energy_line2_wh,
               energy_home_wh, now_ms,
        input  ready
    );
    modport sink (
        input  valid, line1_ok, line2_ok, energy_line1_wh, energy_line2_wh,
               energy_home_wh, now_ms,
        output ready
    );
endinterface

interface mps_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [1:0]  wait_code;
    logic [1:0]  line_action;
    logic        measured;
    logic [31:0] window_line1_wh;
    logic [31:0] window_line2_wh;
    logic [31:0] window_home_wh;
    logic [15:0] avg_power_line1_w;
    logic [15:0] avg_power_line2_w;
    logic [15:0] avg_power_home_w;

    modport source (
        output valid, action, wait_code, line_action, measured,
               window_line1_wh, window_line2_wh, window_home_wh,
               avg_power_line1_w, avg_power_line2_w, avg_power_home_w,
        input  ready
    );
    modport sink (
        input  valid, action, wait_code, line_action, measured,
               window_line1_wh, window_line2_wh, window_home_wh,
               avg_power_line1_w, avg_power_line2_w, avg_power_home_w,
        output ready
    );
endinterface

### rtl/meter_poll_supervisor.sv
// ----------------------------------------------------------------------------
// meter_poll_supervisor
// poll supervisor: energy windows, average power, retry and restart control
// ----------------------------------------------------------------------------
// i_in takes one poll beat (two read statuses, three cumulative energies in
// Wh, a millisecond time); o_out gives exactly one result beat per poll.
// Registers retry_limit (0x0) and restart_limit (0x4) sit on the APB port;
// they must be written by the user only while the block is idle, and the
// block itself does not enforce this. A failed poll or a poll in restart
// mode goes from idle straight to the output state, where its result is
// loaded into the output register; a good poll with no elapsed time takes
// the same path. Otherwise each of the three average powers goes through
// one multiply step and the shared radix-2 divider before the output state;
// the divider gives one quotient bit a cycle, and the sequencer returns to
// idle once the result is loaded.
// i_in.ready is high only while the sequencer is idle, so one poll is in
// work at a time; a finished result waits in the output register, and the
// sequencer holds it back while the receiver stalls.
// Reset clears all counters, stored totals and the poll time, returns to
// measuring mode and sets both limits to 3.
// ----------------------------------------------------------------------------
module meter_poll_supervisor (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    mps_in_if.sink                           i_in,
    mps_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mps_pkg::AddrW-1:0]        paddr,
    input  logic [mps_pkg::DataW-1:0]        pwdata,
    output logic [mps_pkg::DataW-1:0]        prdata,
    output logic                             pready
);

    localparam int unsigned Lanes    = 3;
    localparam int unsigned StepW    = $clog2(mps_pkg::ProdW);
    localparam logic [StepW-1:0] LastStep = StepW'(mps_pkg::ProdW - 1);
    localparam logic [1:0]       LastLane = 2'(Lanes - 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    typedef struct packed {
        mps_pkg::t_action      action;
        mps_pkg::t_wait        wait_code;
        mps_pkg::t_line_action line_action;
        logic                  measured;
        logic [31:0]           win1;
        logic [31:0]           win2;
        logic [31:0]           winh;
        logic [15:0]           pow1;
        logic [15:0]           pow2;
        logic [15:0]           powh;
    } t_result;

    function automatic logic [mps_pkg::CountW-1:0] bump(
        input logic [mps_pkg::CountW-1:0] c
    );
        return (c < mps_pkg::CountMax) ? c + 1'b1 : mps_pkg::CountMax;
    endfunction

    t_state                          r_state, n_state;
    logic [mps_pkg::LimitW-1:0]      r_retry_limit;
    logic [mps_pkg::LimitW-1:0]      r_restart_limit;
    logic                            r_restart_mode;
    logic [mps_pkg::CountW-1:0]      r_retry_count;
    logic [mps_pkg::CountW-1:0]      r_line1_errors;
    logic [mps_pkg::CountW-1:0]      r_line2_errors;
    logic [mps_pkg::CountW-1:0]      r_restart_count;
    logic [31:0]                     r_last1;
    logic [31:0]                     r_last2;
    logic [31:0]                     r_lasth;
    logic [31:0]                     r_last_ms;

    // result under construction
    mps_pkg::t_action                r_action;
    mps_pkg::t_wait                  r_wait;
    mps_pkg::t_line_action           r_line;
    logic                            r_measured;
    logic [31:0]                     r_win [Lanes];
    logic [15:0]                     r_pow [Lanes];

    // shared divider
    logic [1:0]                      r_lane;
    logic [31:0]                     r_elapsed;
    logic [mps_pkg::ProdW-1:0]       r_prod;
    logic [31:0]                     r_rem;
    logic [15:0]                     r_quo;
    logic [StepW-1:0]                r_step;

    // output register
    t_result                         r_out;
    logic                            r_out_valid;

    logic                            w_in_beat;
    logic                            w_cfg_wr;
    logic                            w_out_free;
    logic [mps_pkg::CountW-1:0]      w_retry_bump;
    logic [mps_pkg::CountW-1:0]      w_l1_next;
    logic [mps_pkg::CountW-1:0]      w_l2_next;
    logic [mps_pkg::CountW-1:0]      w_restart_bump;
    logic [31:0]                     w_elapsed;
    logic [31:0]                     w_new1;
    logic [31:0]                     w_new2;
    logic [31:0]                     w_newh;
    logic [mps_pkg::ProdW-1:0]       w_prod;
    logic [32:0]                     w_shift;
    logic [32:0]                     w_diff;
    logic                            w_ge;

    // handshakes
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_beat   = i_in.valid && i_in.ready;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign pready      = 1'b1;

    // register readback
    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            mps_pkg::RegRetryLimit:   prdata = {{(mps_pkg::DataW-mps_pkg::LimitW){1'b0}},
                                                r_retry_limit};
            mps_pkg::RegRestartLimit: prdata = {{(mps_pkg::DataW-mps_pkg::LimitW){1'b0}},
                                                r_restart_limit};
            default:                  prdata = '0;
        endcase
    end

    // counter updates for a poll
    assign w_retry_bump   = bump(r_retry_count);
    assign w_restart_bump = bump(r_restart_count);
    assign w_l1_next      = i_in.line1_ok ? r_line1_errors : bump(r_line1_errors);
    assign w_l2_next      = i_in.line2_ok ? r_line2_errors : bump(r_line2_errors);

    // windows and elapsed time of a good poll
    assign w_elapsed = (r_last_ms != '0) ? i_in.now_ms - r_last_ms : '0;
    assign w_new1    = (r_last1 != '0) ? i_in.energy_line1_wh - r_last1 : '0;
    assign w_new2    = (r_last2 != '0) ? i_in.energy_line2_wh - r_last2 : '0;
    assign w_newh    = (r_lasth != '0) ? i_in.energy_home_wh - r_lasth : '0;

    // energy times ms per hour
    assign w_prod = {{mps_pkg::MsPerHourW{1'b0}}, r_win[r_lane]}
                  * {{mps_pkg::EnergyW{1'b0}}, mps_pkg::MsPerHour};

    // one restoring divide step
    assign w_shift = {r_rem, r_prod[mps_pkg::ProdW-1]};
    assign w_diff  = w_shift - {1'b0, r_elapsed};
    assign w_ge    = (w_shift >= {1'b0, r_elapsed});

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    if (!r_restart_mode && i_in.line1_ok && i_in.line2_ok &&
                        (w_elapsed != '0)) begin
                        n_state = ST_MUL;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_MUL: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == LastStep) begin
                    n_state = (r_lane == LastLane) ? ST_OUT : ST_MUL;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_retry_limit   <= mps_pkg::RetryLimitRst;
            r_restart_limit <= mps_pkg::RestartLimitRst;
            r_restart_mode  <= 1'b0;
            r_retry_count   <= '0;
            r_line1_errors  <= '0;
            r_line2_errors  <= '0;
            r_restart_count <= '0;
            r_last1         <= '0;
            r_last2         <= '0;
            r_lasth         <= '0;
            r_last_ms       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;

            // register writes
            if (w_cfg_wr) begin
                unique case (paddr[2])
                    mps_pkg::RegRetryLimit:   r_retry_limit   <= pwdata[mps_pkg::LimitW-1:0];
                    mps_pkg::RegRestartLimit: r_restart_limit <= pwdata[mps_pkg::LimitW-1:0];
                    default: ;
                endcase
            end

            // poll decision
            if (w_in_beat) begin
                if (r_restart_mode) begin
                    r_restart_mode <= 1'b0;
                    if (w_restart_bump > {1'b0, r_restart_limit}) begin
                        r_restart_count <= '0;
                    end else begin
                        r_restart_count <= w_restart_bump;
                    end
                end else if (!i_in.line1_ok || !i_in.line2_ok) begin
                    if (w_retry_bump > {1'b0, r_retry_limit}) begin
                        r_retry_count  <= '0;
                        r_line1_errors <= '0;
                        r_line2_errors <= '0;
                        r_restart_mode <= 1'b1;
                    end else begin
                        r_retry_count  <= w_retry_bump;
                        r_line1_errors <= w_l1_next;
                        r_line2_errors <= w_l2_next;
                    end
                end else begin
                    r_retry_count  <= '0;
                    r_line1_errors <= '0;
                    r_line2_errors <= '0;
                    r_last1        <= i_in.energy_line1_wh;
                    r_last2        <= i_in.energy_line2_wh;
                    r_lasth        <= i_in.energy_home_wh;
                    r_last_ms      <= i_in.now_ms;
                end
            end

            // output register: load a new beat or drop the taken one
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result and divider datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_beat) begin
                    r_lane    <= '0;
                    r_elapsed <= w_elapsed;
                    for (int k = 0; k < Lanes; k++) begin
                        r_pow[k] <= '0;
                    end
                    if (r_restart_mode) begin
                        r_line     <= mps_pkg::LINE_ON_BOTH;
                        r_measured <= 1'b0;
                        for (int k = 0; k < Lanes; k++) begin
                            r_win[k] <= '0;
                        end
                        if (w_restart_bump > {1'b0, r_restart_limit}) begin
                            r_action <= mps_pkg::ACT_ERROR;
                            r_wait   <= mps_pkg::WAIT_100MS;
                        end else begin
                            r_action <= mps_pkg::ACT_STAY;
                            r_wait   <= mps_pkg::WAIT_30S;
                        end
                    end else if (!i_in.line1_ok || !i_in.line2_ok) begin
                        r_action   <= mps_pkg::ACT_STAY;
                        r_wait     <= mps_pkg::WAIT_5S;
                        r_measured <= 1'b0;
                        for (int k = 0; k < Lanes; k++) begin
                            r_win[k] <= '0;
                        end
                        // past the retry limit, name a line with errors
                        if ((w_retry_bump > {1'b0, r_retry_limit}) && (w_l1_next != '0)) begin
                            r_line <= mps_pkg::LINE_OFF_1;
                        end else if ((w_retry_bump > {1'b0, r_retry_limit}) &&
                                     (w_l2_next != '0)) begin
                            r_line <= mps_pkg::LINE_OFF_2;
                        end else begin
                            r_line <= mps_pkg::LINE_NONE;
                        end
                    end else begin
                        r_action   <= mps_pkg::ACT_ADVANCE;
                        r_wait     <= mps_pkg::WAIT_100MS;
                        r_line     <= mps_pkg::LINE_NONE;
                        r_measured <= 1'b1;
                        r_win[0]   <= w_new1;
                        r_win[1]   <= w_new2;
                        r_win[2]   <= w_newh;
                    end
                end
            end
            ST_MUL: begin
                r_prod <= w_prod;
                r_rem  <= '0;
                r_step <= '0;
            end
            ST_DIV: begin
                r_prod <= {r_prod[mps_pkg::ProdW-2:0], 1'b0};
                r_rem  <= w_ge ? w_diff[31:0] : w_shift[31:0];
                r_quo  <= {r_quo[14:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == LastStep) begin
                    r_pow[r_lane] <= {r_quo[14:0], w_ge};
                    r_lane        <= r_lane + 1'b1;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_out.action      <= r_action;
                    r_out.wait_code   <= r_wait;
                    r_out.line_action <= r_line;
                    r_out.measured    <= r_measured;
                    r_out.win1        <= r_win[0];
                    r_out.win2        <= r_win[1];
                    r_out.winh        <= r_win[2];
                    r_out.pow1        <= r_pow[0];
                    r_out.pow2        <= r_pow[1];
                    r_out.powh        <= r_pow[2];
                end
            end
            default: ;
        endcase
    end

    // result beat
    assign o_out.valid             = r_out_valid;
    assign o_out.action            = r_out.action;
    assign o_out.wait_code         = r_out.wait_code;
    assign o_out.line_action       = r_out.line_action;
    assign o_out.measured          = r_out.measured;
    assign o_out.window_line1_wh   = r_out.win1;
    assign o_out.window_line2_wh   = r_out.win2;
    assign o_out.window_home_wh    = r_out.winh;
    assign o_out.avg_power_line1_w = r_out.pow1;
    assign o_out.avg_power_line2_w = r_out.pow2;
    assign o_out.avg_power_home_w  = r_out.powh;

endmodule

### rtl/mps_checker.sv
// ----------------------------------------------------------------------------
// mps_checker
// port-level checks of the meter poll supervisor, bound to the top level
// ----------------------------------------------------------------------------
module mps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_action,
    input logic [1:0]  i_wait_code,
    input logic [1:0]  i_line_action,
    input logic        i_measured,
    input logic [31:0] i_win1,
    input logic [31:0] i_win2,
    input logic [31:0] i_winh,
    input logic [15:0] i_pow1,
    input logic [15:0] i_pow2,
    input logic [15:0] i_powh
);

    // no result beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // one poll in work at a time
    a_one_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("poll taken while another is in work");

    // a stalled result beat stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // unmeasured results carry no energy or power
    a_unmeasured_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_measured |->
            (i_win1 == '0) && (i_win2 == '0) && (i_winh == '0) &&
            (i_pow1 == '0) && (i_pow2 == '0) && (i_powh == '0))
        else $error("unmeasured result with nonzero fields");

    // an error only ends a restart, with both lines powered on
    a_error_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_action == mps_pkg::ACT_ERROR) |->
            (i_line_action == mps_pkg::LINE_ON_BOTH) &&
            (i_wait_code == mps_pkg::WAIT_100MS) && !i_measured)
        else $error("error result outside a restart");

endmodule

bind meter_poll_supervisor mps_checker u_mps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_action      (o_out.action),
    .i_wait_code   (o_out.wait_code),
    .i_line_action (o_out.line_action),
    .i_measured    (o_out.measured),
    .i_win1        (o_out.window_line1_wh),
    .i_win2        (o_out.window_line2_wh),
    .i_winh        (o_out.window_home_wh),
    .i_pow1        (o_out.avg_power_line1_w),
    .i_pow2        (o_out.avg_power_line2_w),
    .i_powh        (o_out.avg_power_home_w)
);
